### hw/rtl/mmos_pkg.sv
package mmos_pkg;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned ID_BITS    = 16;
  localparam int unsigned LEVEL_BITS = 8;
  localparam int unsigned KEY_BITS   = LEVEL_BITS + ID_BITS;

  // port widths of the command and result fields
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOCHANGE = 2'd3
  } status_e;

  typedef logic [KEY_BITS-1:0] key_t;

  // per-cell controls, broadcast along the chain
  typedef struct packed {
    logic capture;  // latch compare flags against the probe key
    logic add;      // open a slot at the insertion point
    logic remove;   // close the slot of the matching entry
  } cell_ctl_t;

endpackage

### hw/rtl/mmos_cell.sv
module mmos_cell
  import mmos_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  key_t      probe_key_i,
  input  key_t      left_key_i,
  input  logic      left_valid_i,
  input  logic      left_lt_i,
  input  key_t      right_key_i,
  input  logic      right_valid_i,
  output key_t      key_o,
  output logic      valid_o,
  output logic      lt_o,
  output logic      eq_o
);

  key_t key_q, key_d;
  logic valid_q, valid_d;
  logic lt_q, lt_d;
  logic eq_q, eq_d;

  always_comb begin
    lt_d    = lt_q;
    eq_d    = eq_q;
    key_d   = key_q;
    valid_d = valid_q;
    if (ctl_i.capture) begin
      lt_d = valid_q && (key_q < probe_key_i);
      eq_d = valid_q && (key_q == probe_key_i);
    end
    // entries below the probe key stay put
    if (ctl_i.add && !lt_q) begin
      if (!left_lt_i) begin
        key_d   = left_key_i;
        valid_d = left_valid_i;
      end else begin
        key_d   = probe_key_i;
        valid_d = 1'b1;
      end
    end else if (ctl_i.remove && !lt_q) begin
      key_d   = right_key_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      lt_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      lt_q    <= lt_d;
      eq_q    <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign valid_o = valid_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule

### hw/rtl/min_max_ordered_set.sv
// Ordered set of up to CAPACITY distinct (level, id) entries, kept sorted in
// a row of cells, least entry in cell 0. Every command gives one result. At
// the transfer every cell compares its entry with the command key; then the
// row shifts one place for an add or remove that changes the set, and the
// result is registered; the next command is taken the cycle after. A result
// that waits on the output holds the command in the shift cycle until it is
// taken. No clearing pass is needed after reset.
module min_max_ordered_set
  import mmos_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [ID_W-1:0]     problem_id_i,
  input  logic [LEVEL_W-1:0]  level_i,
  input  logic                want_greatest_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ID_W-1:0]     result_id_o,
  output logic [STATUS_W-1:0] status_o
);

  logic busy_q;
  logic [KIND_W-1:0] kind_q;
  logic want_q;
  key_t key_q;
  key_t in_key;
  key_t probe_key;

  logic out_valid_q;
  logic [ID_W-1:0] result_id_q, result_id_d;
  status_e status_q, status_d;

  key_t cell_key   [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_lt;
  logic [CAPACITY-1:0] cell_eq;
  cell_ctl_t ctl;

  logic in_xfer, apply, found, full, empty;
  key_t max_key;

  assign in_key    = {LEVEL_BITS'(level_i), ID_BITS'(problem_id_i)};
  assign probe_key = busy_q ? key_q : in_key;

  assign in_ready_o = !busy_q;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign apply      = busy_q && (!out_valid_q || out_ready_i);

  assign found = |cell_eq;
  assign full  = cell_valid[CAPACITY-1];
  assign empty = !cell_valid[0];

  assign ctl.capture = in_xfer;
  assign ctl.add     = apply && (kind_q == KIND_ADD) && !found && !full;
  assign ctl.remove  = apply && (kind_q == KIND_REMOVE) && found;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t lkey, rkey;
    logic lvalid, llt, rvalid;
    if (i == 0) begin : g_first
      assign lkey   = '0;
      assign lvalid = 1'b1;
      assign llt    = 1'b1;
    end else begin : g_left
      assign lkey   = cell_key[i-1];
      assign lvalid = cell_valid[i-1];
      assign llt    = cell_lt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rkey   = '0;
      assign rvalid = 1'b0;
    end else begin : g_right
      assign rkey   = cell_key[i+1];
      assign rvalid = cell_valid[i+1];
    end
    mmos_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .probe_key_i  (probe_key),
      .left_key_i   (lkey),
      .left_valid_i (lvalid),
      .left_lt_i    (llt),
      .right_key_i  (rkey),
      .right_valid_i(rvalid),
      .key_o        (cell_key[i]),
      .valid_o      (cell_valid[i]),
      .lt_o         (cell_lt[i]),
      .eq_o         (cell_eq[i])
    );
  end

  // the greatest entry is the last valid cell
  always_comb begin
    max_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_valid[i] && ((i == CAPACITY - 1) || !cell_valid[(i+1) % CAPACITY])) begin
        max_key = max_key | cell_key[i];
      end
    end
  end

  always_comb begin
    result_id_d = '0;
    status_d    = ST_NOCHANGE;
    unique case (kind_q)
      KIND_QUERY: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          status_d    = ST_OK;
          result_id_d = want_q ? ID_W'(max_key[ID_BITS-1:0])
                               : ID_W'(cell_key[0][ID_BITS-1:0]);
        end
      end
      KIND_ADD: begin
        if (found) begin
          status_d = ST_NOCHANGE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_OK;
        end
      end
      KIND_REMOVE: begin
        status_d = found ? ST_OK : ST_NOCHANGE;
      end
      default: begin
        status_d = ST_NOCHANGE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy_q <= 1'b1;
      end else if (apply) begin
        busy_q <= 1'b0;
      end
      if (apply) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q <= kind_i;
      want_q <= want_greatest_i;
      key_q  <= in_key;
    end
    if (apply) begin
      result_id_q <= result_id_d;
      status_q    <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_id_o = result_id_q;
  assign status_o    = status_q;

  // occupied cells always form a run starting at cell 0
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("occupied cells are not contiguous");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> busy_q && !in_ready_o)
    else $error("command not held after transfer");

  a_apply_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply |=> out_valid_o && !busy_q)
    else $error("shift cycle did not post a result");

  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> result_id_o == '0)
    else $error("nonzero id on a failed command");

  a_one_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.add && ctl.remove))
    else $error("add and remove in one cycle");

endmodule
